FILE: hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define CHK_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed");

// antecedent implies consequent in the next cycle, off during reset
`define CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed");

// condition that holds in the cycle after reset
`define CHK_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("reset check failed");

`endif

FILE: hw/rtl/wora_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wora_pkg
// shared types, constants and tables of the windowed outlier-rejecting average
// ----------------------------------------------------------------------------
package wora_pkg;

   // point field width and default window radius limit
   localparam int VALUE_BITS     = 32;
   localparam int DEF_MAX_RADIUS = 8;

   // log2 format: 5 integer bits, 16 fraction bits
   localparam int FRAC_W = 16;
   localparam int LOG_W  = 21;

   // configuration register indexes
   localparam logic CSR_LOG_MODE = 1'b0;
   localparam logic CSR_RADIUS   = 1'b1;

   // channel codes
   localparam logic [1:0] CH_VALUE = 2'd0;
   localparam logic [1:0] CH_LOW   = 2'd1;
   localparam logic [1:0] CH_HIGH  = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       mem_we;
      logic       mem_re;
      logic       ld_ctr;
      logic       cnt_inc;
      logic       acc_lin;
      logic       log_init;
      logic       log_step;
      logic       log_add;
      logic       div_init;
      logic       div_step;
      logic       div_done;
      logic       exp_step;
      logic       exp_done;
      logic       out_load;
      logic       out_eor;
      logic [1:0] ch;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic kept;
      logic ch_zero;
      logic sel_zero;
      logic out_free;
   } dp_status_type;

   // integer square root, bit by bit
   function automatic logic [63:0] isqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      begin
         v = v_arg;
         r = 64'd0;
         b = 64'd1 << 62;
         for (int i = 0; i < 32; i++) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      end
   endfunction

   // roots 2^(2^-k) in q1.30 for k = 1..16
   typedef logic [31:0] root_tab_type [16];

   function automatic root_tab_type build_roots();
      root_tab_type tab;
      logic [63:0]  r;
      begin
         r = isqrt64(64'd2 << 60);
         for (int k = 0; k < 16; k++) begin
            tab[k] = r[31:0];
            r = isqrt64(r << 30);
         end
         return tab;
      end
   endfunction

   localparam root_tab_type EXP_ROOT = build_roots();

endpackage

FILE: hw/rtl/windowed_outlier_rejecting_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_outlier_rejecting_average
// sliding-window mean of points with outlier gate, linear or geometric
// ----------------------------------------------------------------------------
// usage:
//  req_* carries one point (value, err_low, err_high, last) per item; an item
//  is taken when req_valid is high and req_stall is low. rsp_* returns one
//  smoothed point per item in the same way, lagging the input by the radius;
//  an item with last set flushes all pending centres, the final result with
//  rsp_end_of_run set. csr_* writes log_mode (index 0) and window_radius
//  (index 1); the user must do so only while the block is idle (unchecked).
// sequencing:
//  an input is taken only in the idle state; the block then produces every
//  result that it causes before it takes the next input. each result walks
//  the W window points and runs S = 32 + clog2(2*MAX_RADIUS+2) divider steps
//  per channel (S = 37 at radius limit 8); log mode adds log2 steps for each
//  nonzero channel of a kept point and exp2 steps for each nonzero channel.
//  the shared 32x32 multiplier, the one window memory read port and the
//  bit-serial divider keep this work serial.
// reset and stall:
//  reset empties the run and sets log_mode 0, radius 2. a stalled result is
//  held in the output register; the block waits before the next result.
// ----------------------------------------------------------------------------
module windowed_outlier_rejecting_average
   import wora_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [VALUE_BITS-1:0] req_err_low,
   input  logic [VALUE_BITS-1:0] req_err_high,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_smooth_value,
   output logic [VALUE_BITS-1:0] rsp_smooth_err_low,
   output logic [VALUE_BITS-1:0] rsp_smooth_err_high,
   output logic                  rsp_end_of_run,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [3:0]            csr_wdata
);

   localparam int WIN    = 2 * MAX_RADIUS + 1;
   localparam int IDX_W  = $clog2(WIN + 1);
   localparam int STEP_W = $clog2(VALUE_BITS + IDX_W);

   logic              log_mode_ff;
   logic [3:0]        radius_ff;
   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_addr;
   logic [STEP_W-1:0] step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         log_mode_ff <= 1'b0;
         radius_ff   <= 4'd2;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOG_MODE: log_mode_ff <= csr_wdata[0];
            CSR_RADIUS:   radius_ff   <= csr_wdata;
            default:      radius_ff   <= radius_ff;
         endcase
      end
   end

   wora_ctrl #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .log_mode  (log_mode_ff),
      .radius    (radius_ff),
      .status    (status),
      .cmd       (cmd),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .step      (step)
   );

   wora_dp #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .wr_addr             (wr_addr),
      .rd_addr             (rd_addr),
      .step                (step),
      .log_mode            (log_mode_ff),
      .req_value           (req_value),
      .req_err_low         (req_err_low),
      .req_err_high        (req_err_high),
      .status              (status),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_smooth_value    (rsp_smooth_value),
      .rsp_smooth_err_low  (rsp_smooth_err_low),
      .rsp_smooth_err_high (rsp_smooth_err_high),
      .rsp_end_of_run      (rsp_end_of_run)
   );

endmodule

FILE: hw/rtl/wora_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wora_dp
// window memory, gate, accumulators, log2/exp2 multiplier, divider, output
// ----------------------------------------------------------------------------
module wora_dp
   import wora_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [$clog2(2*MAX_RADIUS+2)-1:0] wr_addr,
   input  logic [$clog2(2*MAX_RADIUS+2)-1:0] rd_addr,
   input  logic [$clog2(VALUE_BITS+$clog2(2*MAX_RADIUS+2))-1:0] step,
   input  logic                  log_mode,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [VALUE_BITS-1:0] req_err_low,
   input  logic [VALUE_BITS-1:0] req_err_high,
   output dp_status_type         status,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_smooth_value,
   output logic [VALUE_BITS-1:0] rsp_smooth_err_low,
   output logic [VALUE_BITS-1:0] rsp_smooth_err_high,
   output logic                  rsp_end_of_run
);

   localparam int WIN    = 2 * MAX_RADIUS + 1;
   localparam int IDX_W  = $clog2(WIN + 1);
   localparam int SUM_W  = VALUE_BITS + IDX_W;
   localparam int VW     = VALUE_BITS;

   // window memory, one entry holds all three channels
   logic [3*VW-1:0] mem [WIN];
   logic [3*VW-1:0] rd_data_ff;

   logic [VW-1:0]    y0_ff;
   logic [SUM_W-1:0] sum_ff [3];
   logic [2:0]       zero_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic [31:0]      m_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [4:0]       p_ff;
   logic [SUM_W-1:0] quo_ff;
   logic [IDX_W-1:0] rem_ff;
   logic [VW-1:0]    res_ff [3];
   logic             rsp_valid_ff;
   logic [VW-1:0]    out_ff [3];
   logic             eor_ff;

   logic [VW-1:0]    rd_ch [3];
   logic [VW-1:0]    sel_x;
   logic [VW-1:0]    y;
   logic [VW-1:0]    diff;
   logic [VW+3:0]    diff10;
   logic             kept;
   logic [4:0]       lead;
   logic [31:0]      norm;
   logic [31:0]      mul_b;
   logic [63:0]      prod;
   logic [31:0]      m_sq;
   logic [IDX_W:0]   trial;
   logic             q_bit;
   logic [4:0]       ip;
   logic [31:0]      exp_out;
   logic [3:0]       exp_k;

   // memory write on accept, registered read
   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[wr_addr] <= {req_err_high, req_err_low, req_value};
      end
      if (cmd.mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      rd_ch[0] = rd_data_ff[VW-1:0];
      rd_ch[1] = rd_data_ff[2*VW-1:VW];
      rd_ch[2] = rd_data_ff[3*VW-1:2*VW];
   end

   always_comb begin
      case (cmd.ch)
         CH_VALUE: sel_x = rd_ch[0];
         CH_LOW:   sel_x = rd_ch[1];
         CH_HIGH:  sel_x = rd_ch[2];
         default:  sel_x = rd_ch[0];
      endcase
   end

   // closeness gate against the centre value
   always_comb begin
      y      = rd_ch[0];
      diff   = (y > y0_ff) ? (y - y0_ff) : (y0_ff - y);
      diff10 = {diff, 3'b000} + {2'b00, diff, 1'b0};
      if (log_mode) begin
         kept = ({1'b0, y} <= {y0_ff, 1'b0}) && ({1'b0, y0_ff} <= {y, 1'b0});
      end else begin
         kept = diff10 <= {4'b0000, y0_ff};
      end
   end

   // leading one and normalization to q1.30
   always_comb begin
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (sel_x[i]) begin
            lead = 5'(i);
         end
      end
      if (lead == 5'd31) begin
         norm = sel_x >> 1;
      end else begin
         norm = sel_x << (5'd30 - lead);
      end
   end

   // shared q1.30 multiplier for log2 squaring and exp2 roots
   always_comb begin
      exp_k = step[3:0];
      mul_b = cmd.exp_step ? EXP_ROOT[exp_k] : m_ff;
      prod  = 64'(m_ff) * 64'(mul_b);
      m_sq  = prod[61:30];
   end

   // restoring divider step
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      q_bit = trial >= {1'b0, cnt_ff};
   end

   // exp2 integer part shift
   always_comb begin
      ip = quo_ff[LOG_W-1:FRAC_W];
      if (ip >= 5'd30) begin
         exp_out = m_ff << (ip - 5'd30);
      end else begin
         exp_out = m_ff >> (5'd30 - ip);
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.ld_ctr) begin
         y0_ff   <= rd_ch[0];
         cnt_ff  <= '0;
         zero_ff <= 3'b000;
         for (int c = 0; c < 3; c++) begin
            sum_ff[c] <= '0;
         end
      end
      if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.acc_lin) begin
         for (int c = 0; c < 3; c++) begin
            sum_ff[c] <= sum_ff[c] + SUM_W'(rd_ch[c]);
         end
      end
      if (cmd.log_init) begin
         p_ff    <= lead;
         m_ff    <= norm;
         frac_ff <= '0;
         if (sel_x == '0) begin
            zero_ff[cmd.ch] <= 1'b1;
         end
      end
      if (cmd.log_step) begin
         if (m_sq[31]) begin
            m_ff    <= m_sq >> 1;
            frac_ff <= {frac_ff[FRAC_W-2:0], 1'b1};
         end else begin
            m_ff    <= m_sq;
            frac_ff <= {frac_ff[FRAC_W-2:0], 1'b0};
         end
      end
      if (cmd.log_add) begin
         sum_ff[cmd.ch] <= sum_ff[cmd.ch] + SUM_W'({p_ff, frac_ff});
      end
      if (cmd.div_init) begin
         quo_ff <= sum_ff[cmd.ch];
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[SUM_W-2:0], q_bit};
         rem_ff <= q_bit ? IDX_W'(trial - {1'b0, cnt_ff}) : IDX_W'(trial);
      end
      if (cmd.div_done) begin
         if (!log_mode) begin
            res_ff[cmd.ch] <= quo_ff[VW-1:0];
         end else if (zero_ff[cmd.ch]) begin
            res_ff[cmd.ch] <= '0;
         end else begin
            m_ff <= 32'd1 << 30;
         end
      end
      if (cmd.exp_step) begin
         if (quo_ff[4'(FRAC_W-1) - exp_k]) begin
            m_ff <= m_sq;
         end
      end
      if (cmd.exp_done) begin
         res_ff[cmd.ch] <= exp_out;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff[0] <= res_ff[0];
         out_ff[1] <= res_ff[1];
         out_ff[2] <= res_ff[2];
         eor_ff    <= cmd.out_eor;
      end
   end

   always_comb begin
      status.kept     = kept;
      status.ch_zero  = (sel_x == '0);
      status.sel_zero = zero_ff[cmd.ch];
      status.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_smooth_value    = out_ff[0];
   assign rsp_smooth_err_low  = out_ff[1];
   assign rsp_smooth_err_high = out_ff[2];
   assign rsp_end_of_run      = eor_ff;

endmodule

FILE: hw/rtl/wora_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wora_ctrl
// sequencer: run counters, window walk, log/divide/exp steps, result push
// ----------------------------------------------------------------------------
module wora_ctrl
   import wora_pkg::*;
#(
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_stall,
   input  logic                  log_mode,
   input  logic [3:0]            radius,
   input  dp_status_type         status,
   output dp_cmd_type            cmd,
   output logic [$clog2(2*MAX_RADIUS+2)-1:0] wr_addr,
   output logic [$clog2(2*MAX_RADIUS+2)-1:0] rd_addr,
   output logic [$clog2(VALUE_BITS+$clog2(2*MAX_RADIUS+2))-1:0] step
);

   localparam int WIN    = 2 * MAX_RADIUS + 1;
   localparam int IDX_W  = $clog2(WIN + 1);
   localparam int SUM_W  = VALUE_BITS + IDX_W;
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [14:0] {
      ST_IDLE     = 15'b000000000000001,
      ST_START    = 15'b000000000000010,
      ST_RD_CTR   = 15'b000000000000100,
      ST_LD_CTR   = 15'b000000000001000,
      ST_RD_PT    = 15'b000000000010000,
      ST_CHK      = 15'b000000000100000,
      ST_LOG_INIT = 15'b000000001000000,
      ST_LOG_STEP = 15'b000000010000000,
      ST_LOG_ADD  = 15'b000000100000000,
      ST_DIV_INIT = 15'b000001000000000,
      ST_DIV_STEP = 15'b000010000000000,
      ST_DIV_DONE = 15'b000100000000000,
      ST_EXP_STEP = 15'b001000000000000,
      ST_EXP_DONE = 15'b010000000000000,
      ST_PUSH     = 15'b100000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  ws_ff, ws_in;
   logic [IDX_W-1:0]  ps_ff, ps_in;
   logic [IDX_W-1:0]  ncl_ff, ncl_in;
   logic [IDX_W-1:0]  l_ff, l_in;
   logic [IDX_W-1:0]  lend_ff, lend_in;
   logic [1:0]        ch_ff, ch_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_ff, last_in;

   logic [IDX_W-1:0]  rad;
   logic [IDX_W:0]    lag_p1;
   logic [IDX_W-1:0]  left_raw;
   logic [IDX_W-1:0]  left;
   logic [IDX_W-1:0]  right;
   logic              pt_last;

   // ring slot of an entry that lies lag points back from the newest
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] ws,
                                                input logic [IDX_W-1:0] lag);
      logic [IDX_W:0] t;
      begin
         t = {1'b0, ws} + (IDX_W+1)'(WIN - 1) - {1'b0, lag};
         if (t >= (IDX_W+1)'(WIN)) begin
            t = t - (IDX_W+1)'(WIN);
         end
         return t[IDX_W-1:0];
      end
   endfunction

   // radius limited to MAX_RADIUS
   always_comb begin
      if (32'(radius) > 32'(MAX_RADIUS)) begin
         rad = IDX_W'(MAX_RADIUS);
      end else begin
         rad = IDX_W'(radius);
      end
   end

   // window bounds around the centre
   always_comb begin
      lag_p1   = {1'b0, ncl_ff} + 1'b1;
      left_raw = ({1'b0, ps_ff} > lag_p1) ? (ps_ff - ncl_ff - 1'b1) : '0;
      left     = (left_raw > rad) ? rad : left_raw;
      right    = (ncl_ff > rad) ? rad : ncl_ff;
      pt_last  = (l_ff == lend_ff);
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ws_in    = ws_ff;
      ps_in    = ps_ff;
      ncl_in   = ncl_ff;
      l_in     = l_ff;
      lend_in  = lend_ff;
      ch_in    = ch_ff;
      step_in  = step_ff;
      last_in  = last_ff;
      cmd      = '0;
      cmd.ch   = ch_ff;
      wr_addr  = ws_ff;
      rd_addr  = slot_of(ws_ff, l_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.mem_we = 1'b1;
               ws_in      = (ws_ff == IDX_W'(WIN - 1)) ? '0 : ws_ff + 1'b1;
               ps_in      = (ps_ff == IDX_W'(WIN)) ? ps_ff : ps_ff + 1'b1;
               ncl_in     = (ncl_ff == IDX_W'(WIN)) ? ncl_ff : ncl_ff + 1'b1;
               last_in    = req_last;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            if (last_ff ? (ncl_ff != '0) : (ncl_ff > rad)) begin
               ncl_in   = ncl_ff - 1'b1;
               state_in = ST_RD_CTR;
            end else begin
               if (last_ff) begin
                  ps_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_RD_CTR: begin
            cmd.mem_re = 1'b1;
            rd_addr    = slot_of(ws_ff, ncl_ff);
            l_in       = ncl_ff + left;
            lend_in    = ncl_ff - right;
            state_in   = ST_LD_CTR;
         end
         ST_LD_CTR: begin
            cmd.ld_ctr = 1'b1;
            state_in   = ST_RD_PT;
         end
         ST_RD_PT: begin
            cmd.mem_re = 1'b1;
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            if (status.kept && log_mode) begin
               cmd.cnt_inc = 1'b1;
               ch_in       = CH_VALUE;
               state_in    = ST_LOG_INIT;
            end else begin
               if (status.kept) begin
                  cmd.cnt_inc = 1'b1;
                  cmd.acc_lin = 1'b1;
               end
               if (pt_last) begin
                  ch_in    = CH_VALUE;
                  state_in = ST_DIV_INIT;
               end else begin
                  l_in     = l_ff - 1'b1;
                  state_in = ST_RD_PT;
               end
            end
         end
         ST_LOG_INIT, ST_LOG_ADD: begin
            if (state_ff == ST_LOG_INIT) begin
               cmd.log_init = 1'b1;
            end else begin
               cmd.log_add = 1'b1;
            end
            if (state_ff == ST_LOG_INIT && !status.ch_zero) begin
               step_in  = '0;
               state_in = ST_LOG_STEP;
            end else if (ch_ff != CH_HIGH) begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_LOG_INIT;
            end else if (pt_last) begin
               ch_in    = CH_VALUE;
               state_in = ST_DIV_INIT;
            end else begin
               l_in     = l_ff - 1'b1;
               state_in = ST_RD_PT;
            end
         end
         ST_LOG_STEP: begin
            cmd.log_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(FRAC_W - 1)) begin
               state_in = ST_LOG_ADD;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_DIV_DONE;
            end
         end
         ST_DIV_DONE, ST_EXP_DONE: begin
            if (state_ff == ST_DIV_DONE) begin
               cmd.div_done = 1'b1;
            end else begin
               cmd.exp_done = 1'b1;
            end
            if (state_ff == ST_DIV_DONE && log_mode && !status.sel_zero) begin
               step_in  = '0;
               state_in = ST_EXP_STEP;
            end else if (ch_ff != CH_HIGH) begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_DIV_INIT;
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_EXP_STEP: begin
            cmd.exp_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(FRAC_W - 1)) begin
               state_in = ST_EXP_DONE;
            end
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_eor  = last_ff && (ncl_ff == '0);
               state_in     = ST_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ws_ff    <= '0;
         ps_ff    <= '0;
         ncl_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ws_ff    <= ws_in;
         ps_ff    <= ps_in;
         ncl_ff   <= ncl_in;
         last_ff  <= last_in;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      l_ff    <= l_in;
      lend_ff <= lend_in;
      ch_ff   <= ch_in;
      step_ff <= step_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign step      = step_ff;

endmodule

FILE: hw/rtl/wora_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wora_checker
// port-level checks of the windowed outlier-rejecting average
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wora_checker
   import wora_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [VALUE_BITS-1:0] rsp_smooth_value
);

   // a stalled result stays offered
   `CHK_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // a stalled result keeps its value
   `CHK_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_smooth_value))

   // an accepted item keeps the block busy in the next cycle
   `CHK_NEXT(a_busy_after_item, req_valid && !req_stall, req_stall)

   // reset leaves the block ready and with no result
   `CHK_RESET(a_reset_state, !rsp_valid && !req_stall)

endmodule

bind windowed_outlier_rejecting_average wora_checker u_wora_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_smooth_value (rsp_smooth_value)
);

FILE: tb/windowed_outlier_rejecting_average_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_outlier_rejecting_average_checker
// watches the point and result channels and the register port, keeps its own
// copy of the window rings and settings, works out the smoothed points that
// each accepted item causes and compares every accepted result field by field
// ----------------------------------------------------------------------------
module windowed_outlier_rejecting_average_checker
   import wora_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic [VALUE_BITS-1:0] req_err_low,
   input  logic [VALUE_BITS-1:0] req_err_high,
   input  logic                  req_last,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [VALUE_BITS-1:0] rsp_smooth_value,
   input  logic [VALUE_BITS-1:0] rsp_smooth_err_low,
   input  logic [VALUE_BITS-1:0] rsp_smooth_err_high,
   input  logic                  rsp_end_of_run,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [3:0]            csr_wdata,
   output int                    mismatches,
   output int                    pending
);

   localparam int RING = 2 * DEF_MAX_RADIUS + 1;

   typedef struct {
      logic [31:0] value;
      logic [31:0] low;
      logic [31:0] high;
      logic        eor;
   } smooth_point_type;

   // window rings and run bookkeeping
   logic [31:0] val_ring [RING];
   logic [31:0] low_ring [RING];
   logic [31:0] high_ring [RING];
   int          wr_slot;
   int          seen;
   int          centre_lag;
   logic        geo_mode;
   logic [3:0]  radius_reg;

   // roots 2^(2^-k) in q1.30
   logic [63:0] root_q30 [16];

   smooth_point_type expected_q [$];

   // floor square root by bisection
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = 0;
      hi = 64'hFFFF_FFFF;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   initial begin
      logic [63:0] r;
      r = floor_sqrt(64'd2 << 60);
      for (int k = 0; k < 16; k++) begin
         root_q30[k] = r;
         r = floor_sqrt(r << 30);
      end
   end

   function automatic int ring_idx(input int lag);
      return (wr_slot + RING - 1 - (lag % RING)) % RING;
   endfunction

   // outlier gate around the centre value
   function automatic bit admitted(input logic [63:0] c, input logic [63:0] y);
      logic [63:0] d;
      if (geo_mode) return (y <= 2 * c) && (c <= 2 * y);
      d = (y > c) ? y - c : c - y;
      return 10 * d <= c;
   endfunction

   // log2 of a raw integer as unsigned q.16
   function automatic logic [63:0] log2_q16(input logic [63:0] x);
      int          p;
      logic [63:0] m;
      logic [63:0] frac;
      p = 0;
      while (p < 63 && (x >> (p + 1)) != 0) p++;
      m = (p <= 30) ? (x << (30 - p)) : (x >> (p - 30));
      frac = 0;
      for (int i = 0; i < 16; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(p) << 16) | frac;
   endfunction

   // two raised to an unsigned q.16 exponent
   function automatic logic [31:0] pow2_q16(input logic [63:0] e);
      int          ip;
      logic [63:0] m;
      ip = int'(e >> 16);
      m = 64'd1 << 30;
      for (int k = 1; k <= 16; k++)
         if (e[16-k]) m = (m * root_q30[k-1]) >> 30;
      if (ip >= 63) return 0;
      if (ip >= 30) return (ip - 30 < 33) ? 32'(m << (ip - 30)) : 0;
      return 32'(m >> (30 - ip));
   endfunction

   // average of the admitted neighbours of one centre
   function automatic smooth_point_type smooth_at(input int lag, input int rad,
                                                  input logic eor);
      smooth_point_type res;
      logic [63:0]   c;
      logic [63:0]   sum [3];
      logic [63:0]   v [3];
      logic [63:0]   q;
      bit            has_zero [3];
      logic [63:0]   cnt;
      int            left;
      int            right;
      int            sl;
      c = val_ring[ring_idx(lag)];
      cnt = 0;
      for (int ch = 0; ch < 3; ch++) begin
         sum[ch] = 0;
         has_zero[ch] = 0;
      end
      right = (lag < rad) ? lag : rad;
      left = (seen > lag + 1) ? seen - 1 - lag : 0;
      if (left > rad) left = rad;
      for (int pos = lag + left; pos >= lag - right; pos--) begin
         sl = ring_idx(pos);
         v[0] = val_ring[sl];
         v[1] = low_ring[sl];
         v[2] = high_ring[sl];
         if (admitted(c, v[0])) begin
            cnt++;
            for (int ch = 0; ch < 3; ch++) begin
               if (!geo_mode) sum[ch] += v[ch];
               else if (v[ch] == 0) has_zero[ch] = 1;
               else sum[ch] += log2_q16(v[ch]);
            end
         end
      end
      if (cnt == 0) cnt = 1;
      for (int ch = 0; ch < 3; ch++) begin
         q = sum[ch] / cnt;
         if (geo_mode) v[ch] = has_zero[ch] ? 0 : 64'(pow2_q16(q));
         else v[ch] = q;
      end
      res.value = v[0][31:0];
      res.low   = v[1][31:0];
      res.high  = v[2][31:0];
      res.eor   = eor;
      return res;
   endfunction

   // store one point and queue the centres it releases
   task automatic take_point();
      int rad;
      rad = (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(radius_reg);
      val_ring[wr_slot]  = req_value;
      low_ring[wr_slot]  = req_err_low;
      high_ring[wr_slot] = req_err_high;
      wr_slot = (wr_slot + 1) % RING;
      if (seen < RING) seen++;
      if (centre_lag < RING) centre_lag++;
      if (req_last) begin
         while (centre_lag > 0) begin
            centre_lag--;
            expected_q.push_back(smooth_at(centre_lag, rad, centre_lag == 0));
         end
         seen = 0;
      end else begin
         while (centre_lag > rad) begin
            centre_lag--;
            expected_q.push_back(smooth_at(centre_lag, rad, 1'b0));
         end
      end
   endtask

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // compare one result with the oldest expectation
   task automatic check_result();
      smooth_point_type want;
      if (expected_q.size() == 0) begin
         report("unexpected result item", rsp_smooth_value, 0);
      end else begin
         want = expected_q.pop_front();
         if (rsp_smooth_value !== want.value)
            report("smooth_value", rsp_smooth_value, want.value);
         if (rsp_smooth_err_low !== want.low)
            report("smooth_err_low", rsp_smooth_err_low, want.low);
         if (rsp_smooth_err_high !== want.high)
            report("smooth_err_high", rsp_smooth_err_high, want.high);
         if (rsp_end_of_run !== want.eor)
            report("end_of_run", 32'(rsp_end_of_run), 32'(want.eor));
      end
   endtask

   initial begin
      mismatches = 0;
      pending = 0;
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         wr_slot = 0;
         seen = 0;
         centre_lag = 0;
         geo_mode = 1'b0;
         radius_reg = 4'd2;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_LOG_MODE) geo_mode = csr_wdata[0];
            else if (csr_index == CSR_RADIUS) radius_reg = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) take_point();
      end
      pending = expected_q.size();
   end

endmodule

FILE: tb/windowed_outlier_rejecting_average_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_outlier_rejecting_average_tb
// drives runs of points through the smoothing block in both averaging modes
// and over a range of radii, with random gaps and result stalls; a checker
// beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module windowed_outlier_rejecting_average_tb;
   import wora_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 40;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value;
   logic [VALUE_BITS-1:0] req_err_low;
   logic [VALUE_BITS-1:0] req_err_high;
   logic                  req_last;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [VALUE_BITS-1:0] rsp_smooth_value;
   logic [VALUE_BITS-1:0] rsp_smooth_err_low;
   logic [VALUE_BITS-1:0] rsp_smooth_err_high;
   logic                  rsp_end_of_run;
   logic                  csr_we;
   logic                  csr_index;
   logic [3:0]            csr_wdata;
   int                    mismatches;
   int                    pending;

   int   send_idle_pct;
   int   stall_pct;
   int   quiet_cycles;
   int   run_left;
   logic geo;
   logic [31:0] run_base;

   // per-phase settings: mode, radius, idling, result stalls
   logic       phase_geo [NUM_PHASES] = '{0, 0, 0, 1, 1, 0, 1, 0};
   logic [3:0] phase_rad [NUM_PHASES] = '{2, 0, 8, 1, 3, 15, 8, 5};
   int         phase_idle [4] = '{0, 66, 0, 27};
   int         phase_stall [4] = '{0, 0, 66, 27};

   windowed_outlier_rejecting_average uut (.*);

   windowed_outlier_rejecting_average_checker checker_i (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // result stalls
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("windowed_outlier_rejecting_average regression: fail");
         $finish;
      end
   end

   task automatic send_point(input logic [31:0] v, input logic [31:0] lo,
                             input logic [31:0] hi, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_value    = v;
      req_err_low  = lo;
      req_err_high = hi;
      req_last     = last;
      req_valid    = 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_reg(input logic idx, input logic [3:0] data);
      @(negedge clock);
      req_valid = 1'b0;
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // wait until every expected result is back, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // a neighbour of the centre: mostly close, sometimes an outlier
   function automatic logic [31:0] neighbour(input logic [31:0] c);
      logic [63:0] y;
      logic [63:0] d;
      if ($urandom_range(99) < 12) return $urandom;
      if (geo) begin
         y = (64'(c) * $urandom_range(400, 2500)) / 1000;
      end else begin
         d = (64'(c) * $urandom_range(0, 120)) / 1000;
         y = $urandom_range(1) ? 64'(c) + d : 64'(c) - d;
      end
      return (y > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : y[31:0];
   endfunction

   function automatic logic [31:0] pick_base();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1, 255);
         2: return 32'hF000_0000 | $urandom;
         default: return $urandom_range(32'h0001_0000, 32'h0064_0000);
      endcase
   endfunction

   function automatic logic [31:0] pick_err(input logic [31:0] v);
      case ($urandom_range(9))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return v >> $urandom_range(1, 6);
      endcase
   endfunction

   // one random point of the current run
   task automatic send_random(input bit force_last);
      logic [31:0] v;
      if (run_left == 0) begin
         case ($urandom_range(19))
            0: run_left = 1;
            1, 2, 3, 4, 5: run_left = $urandom_range(13, 25);
            default: run_left = $urandom_range(1, 12);
         endcase
         run_base = pick_base();
      end
      v = neighbour(run_base);
      run_left--;
      if (force_last) run_left = 0;
      send_point(v, pick_err(v), pick_err(v), run_left == 0);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value     = '0;
      req_err_low   = '0;
      req_err_high  = '0;
      req_last      = 1'b0;
      rsp_stall     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_LOG_MODE;
      csr_wdata     = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      quiet_cycles  = 0;
      run_left      = 0;
      geo           = 1'b0;
      run_base      = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset settings: gate edge, outlier, field extremes
      send_point(32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      send_point(32'h0001_1999, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      send_point(32'h0001_199A, 32'h0000_8000, 32'h0002_0000, 1'b0);
      send_point(32'h0001_1A00, 32'h1234_5678, 32'h8765_4321, 1'b0);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_point(32'hF000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      // pending centres above a smaller radius flush at once
      send_point(32'h0000_5000, 32'h0000_0100, 32'h0000_0200, 1'b0);
      send_point(32'h0000_5100, 32'h0000_0110, 32'h0000_0210, 1'b0);
      drain();
      write_reg(CSR_RADIUS, 4'd0);
      send_point(32'h0000_5200, 32'h0000_0120, 32'h0000_0220, 1'b0);
      send_point(32'h0000_5300, 32'h0000_0130, 32'h0000_0230, 1'b1);
      drain();

      // directed, geometric mean: ratio two gate edges, zero errors, zero value
      write_reg(CSR_LOG_MODE, 4'd1);
      write_reg(CSR_RADIUS, 4'd2);
      send_point(32'h0002_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
      send_point(32'h0004_0000, 32'h0000_4000, 32'h0002_0000, 1'b0);
      send_point(32'h0001_0000, 32'h0000_4000, 32'h0003_0000, 1'b0);
      send_point(32'h0008_0001, 32'h0000_4000, 32'h0004_0000, 1'b0);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
      send_point(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1);
      send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0005, 1'b0);
      send_point(32'h0000_0000, 32'h0000_0003, 32'h0000_0000, 1'b0);
      send_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b1);
      drain();

      // random phases; runs carry across phase boundaries
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_reg(CSR_LOG_MODE, {3'b000, phase_geo[ph]});
         write_reg(CSR_RADIUS, phase_rad[ph]);
         geo = phase_geo[ph];
         send_idle_pct = phase_idle[ph % 4];
         stall_pct = phase_stall[ph % 4];
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random(ph == NUM_PHASES - 1 && n == PHASE_ITEMS - 1);
         drain();
      end

      if (mismatches == 0)
         $display("windowed_outlier_rejecting_average regression: pass");
      else
         $display("windowed_outlier_rejecting_average regression: fail");
      $finish;
   end

endmodule
